>>> rtl/hat_pkg.sv
// shared constants, codes and control types of the hash accumulate table
package hat_pkg;

	localparam int SLOTS_DEF       = 1024;
	localparam int COUNT_LIMBS_DEF = 2;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [2:0] ST_INSERTED    = 3'd0;
	localparam logic [2:0] ST_ACCUMULATED = 3'd1;
	localparam logic [2:0] ST_READ        = 3'd2;
	localparam logic [2:0] ST_CLEARED     = 3'd3;
	localparam logic [2:0] ST_ZERO_KEY    = 3'd4;
	localparam logic [2:0] ST_TAG_MISS    = 3'd5;
	localparam logic [2:0] ST_OVERFLOW    = 3'd6;
	localparam logic [2:0] ST_FULL        = 3'd7;

	localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
	localparam int          MIX_SH0 = 30;
	localparam int          MIX_SH1 = 27;
	localparam int          MIX_SH2 = 31;

	localparam logic [10:0] LOAD_LIMIT_RST = 11'd714;

	typedef struct packed {
		logic load;
		logic mix_start;
		logic probe_init;
		logic probe_next;
		logic clr_step;
		logic decide;
		logic commit;
	} hat_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       key_zero;
		logic       mix_done;
		logic       empty;
		logic       match;
		logic       wrap;
		logic       clr_last;
		logic       out_free;
	} hat_stat_t;

endpackage

>>> rtl/hat_mix.sv
// iterative 64-bit key mixer on one shared 32x32 multiplier
module hat_mix import hat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [63:0] hash
);

	logic        busy_q;
	logic        second_q;
	logic        done_q;
	logic [1:0]  step_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] pp_q;
	logic [63:0] hash_q;
	logic [63:0] b;
	logic [63:0] pp_add;
	logic [63:0] acc_nxt;
	logic [31:0] ma;
	logic [31:0] mb;

	assign b = second_q ? MIX_C2 : MIX_C1;

	always_comb begin
		case (step_q)
			2'd0: begin
				ma = a_q[31:0];
				mb = b[31:0];
			end
			2'd1: begin
				ma = a_q[31:0];
				mb = b[63:32];
			end
			default: begin
				ma = a_q[63:32];
				mb = b[31:0];
			end
		endcase
	end

	// low partial product lands unshifted, cross products shifted by 32
	assign pp_add  = (step_q == 2'd1) ? pp_q : {pp_q[31:0], 32'd0};
	assign acc_nxt = acc_q + pp_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			second_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= 2'd0;
		end else if (start) begin
			busy_q   <= 1'b1;
			second_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= 2'd0;
		end else if (busy_q) begin
			done_q <= 1'b0;
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				if (second_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					second_q <= 1'b1;
				end
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= key ^ (key >> MIX_SH0);
			acc_q <= 64'd0;
		end else if (busy_q) begin
			pp_q <= {32'd0, ma} * {32'd0, mb};
			if (step_q != 2'd0)
				acc_q <= acc_nxt;
			if (step_q == 2'd3) begin
				acc_q <= 64'd0;
				if (!second_q)
					a_q <= acc_nxt ^ (acc_nxt >> MIX_SH1);
				else
					hash_q <= acc_nxt ^ (acc_nxt >> MIX_SH2);
			end
		end
	end

	assign done = done_q;
	assign hash = hash_q;

endmodule

>>> rtl/hat_datapath.sv
// table memories, probe pointers, count adder and output register
module hat_datapath import hat_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int COUNT_LIMBS = COUNT_LIMBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hat_cmd_t    cmd,
	output hat_stat_t   st,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [63:0] tag,
	input  logic [63:0] count_low,
	input  logic [63:0] count_high,
	input  logic [9:0]  slot_index,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        slot_used,
	output logic [63:0] slot_key,
	output logic [63:0] slot_tag,
	output logic [63:0] sum_low,
	output logic [63:0] sum_high,
	output logic [10:0] entry_total
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = 64 * COUNT_LIMBS;

	logic [63:0]   key_mem [SLOTS];
	logic [63:0]   tag_mem [SLOTS];
	logic [CW-1:0] cnt_mem [SLOTS];

	logic [1:0]    op_q;
	logic [63:0]   key_q;
	logic [63:0]   tag_q;
	logic [CW-1:0] add_q;
	logic [IW-1:0] sidx_q;
	logic [10:0]   limit_q;
	logic [10:0]   occ_q;
	logic [IW-1:0] s_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] clr_q;
	logic [63:0]   key_rd_q;
	logic [63:0]   tag_rd_q;
	logic [CW-1:0] cnt_rd_q;

	logic [2:0]    res_status_q;
	logic          res_used_q;
	logic [63:0]   res_key_q;
	logic [63:0]   res_tag_q;
	logic [127:0]  res_cnt_q;
	logic [10:0]   res_occ_q;
	logic          wkey_q;
	logic          wcnt_q;
	logic [CW-1:0] cntw_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic          out_used_q;
	logic [63:0]   out_key_q;
	logic [63:0]   out_tag_q;
	logic [127:0]  out_cnt_q;
	logic [10:0]   out_occ_q;

	logic          mix_done;
	logic [63:0]   hash;
	logic          empty;
	logic          match;
	logic [CW:0]   sum_w;
	logic [11:0]   occ_inc;

	logic [2:0]    d_status;
	logic          d_used;
	logic [63:0]   d_key;
	logic [63:0]   d_tag;
	logic [127:0]  d_cnt;
	logic [10:0]   d_occ;
	logic          d_wkey;
	logic          d_wcnt;
	logic [CW-1:0] d_cntw;

	logic          key_we;
	logic [IW-1:0] key_wa;
	logic [63:0]   key_wd;

	hat_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mix_start),
		.key    (key_q),
		.done   (mix_done),
		.hash   (hash)
	);

	assign empty   = (key_rd_q == 64'd0);
	assign match   = (key_rd_q == key_q);
	assign sum_w   = {1'b0, cnt_rd_q} + {1'b0, add_q};
	assign occ_inc = {1'b0, occ_q} + 12'd1;

	always_comb begin
		d_status = ST_CLEARED;
		d_used   = 1'b0;
		d_key    = 64'd0;
		d_tag    = 64'd0;
		d_cnt    = 128'd0;
		d_occ    = occ_q;
		d_wkey   = 1'b0;
		d_wcnt   = 1'b0;
		d_cntw   = add_q;
		case (op_q)
			CMD_ADD: begin
				if (key_q == 64'd0) begin
					d_status = ST_ZERO_KEY;
				end else if (match) begin
					if (tag_rd_q != tag_q) begin
						d_status = ST_TAG_MISS;
					end else if (sum_w[CW]) begin
						d_status = ST_OVERFLOW;
					end else begin
						d_status = ST_ACCUMULATED;
						d_used   = 1'b1;
						d_key    = key_q;
						d_tag    = tag_q;
						d_cnt    = 128'(sum_w[CW-1:0]);
						d_wcnt   = 1'b1;
						d_cntw   = sum_w[CW-1:0];
					end
				end else if (empty && !(occ_inc > {1'b0, limit_q})) begin
					d_status = ST_INSERTED;
					d_used   = 1'b1;
					d_key    = key_q;
					d_tag    = tag_q;
					d_cnt    = 128'(add_q);
					d_occ    = occ_inc[10:0];
					d_wkey   = 1'b1;
					d_wcnt   = 1'b1;
				end else begin
					d_status = ST_FULL;
				end
			end
			CMD_READ: begin
				d_status = ST_READ;
				if (!empty) begin
					d_used = 1'b1;
					d_key  = key_rd_q;
					d_tag  = tag_rd_q;
					d_cnt  = 128'(cnt_rd_q);
				end
			end
			default: begin
				d_status = ST_CLEARED;
				d_occ    = 11'd0;
			end
		endcase
	end

	// key memory: clearing sweep or insert
	assign key_we = cmd.clr_step | (cmd.commit & wkey_q);
	assign key_wa = cmd.clr_step ? clr_q : s_q;
	assign key_wd = cmd.clr_step ? 64'd0 : res_key_q;

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_wa] <= key_wd;
		key_rd_q <= key_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wkey_q)
			tag_mem[s_q] <= res_tag_q;
		tag_rd_q <= tag_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wcnt_q)
			cnt_mem[s_q] <= cntw_q;
		cnt_rd_q <= cnt_mem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= CMD_NONE;
			limit_q     <= LOAD_LIMIT_RST;
			occ_q       <= 11'd0;
			s_q         <= '0;
			n_q         <= '0;
			clr_q       <= '0;
			wkey_q      <= 1'b0;
			wcnt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				op_q <= command;
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (cmd.probe_init) begin
				s_q <= (op_q == CMD_READ) ? sidx_q : hash[IW-1:0];
				n_q <= '0;
			end else if (cmd.probe_next) begin
				s_q <= s_q + 1'b1;
				n_q <= n_q + 1'b1;
			end
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.decide) begin
				wkey_q <= d_wkey;
				wcnt_q <= d_wcnt;
			end
			if (cmd.commit) begin
				occ_q       <= res_occ_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key;
			tag_q  <= tag;
			add_q  <= CW'({count_high, count_low});
			sidx_q <= IW'(slot_index);
		end
		if (cmd.decide) begin
			res_status_q <= d_status;
			res_used_q   <= d_used;
			res_key_q    <= d_key;
			res_tag_q    <= d_tag;
			res_cnt_q    <= d_cnt;
			res_occ_q    <= d_occ;
			cntw_q       <= d_cntw;
		end
		if (cmd.commit) begin
			out_status_q <= res_status_q;
			out_used_q   <= res_used_q;
			out_key_q    <= res_key_q;
			out_tag_q    <= res_tag_q;
			out_cnt_q    <= res_cnt_q;
			out_occ_q    <= res_occ_q;
		end
	end

	assign st.op       = op_q;
	assign st.key_zero = (key_q == 64'd0);
	assign st.mix_done = mix_done;
	assign st.empty    = empty;
	assign st.match    = match;
	assign st.wrap     = (n_q == {IW{1'b1}});
	assign st.clr_last = (clr_q == {IW{1'b1}});
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slot_used   = out_used_q;
	assign slot_key    = out_key_q;
	assign slot_tag    = out_tag_q;
	assign sum_low     = out_cnt_q[63:0];
	assign sum_high    = out_cnt_q[127:64];
	assign entry_total = out_occ_q;

endmodule

>>> rtl/hat_ctrl.sv
// controller state machine sequencing hash, probe, clear and commit
module hat_ctrl import hat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  hat_stat_t st,
	output hat_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_HASH,
		S_WAIT,
		S_CHK,
		S_CLR,
		S_DECIDE,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   stop;

	assign stop = st.empty | st.match | st.wrap;

	always_comb begin
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.mix_start  = (state_q == S_DISPATCH) && (st.op == CMD_ADD) && !st.key_zero;
		cmd.probe_init = ((state_q == S_DISPATCH) && (st.op == CMD_READ)) ||
		                 ((state_q == S_HASH) && st.mix_done);
		cmd.probe_next = (state_q == S_CHK) && (st.op == CMD_ADD) && !stop;
		cmd.clr_step   = (state_q == S_INIT) || (state_q == S_CLR);
		cmd.decide     = (state_q == S_DECIDE);
		cmd.commit     = (state_q == S_COMMIT) && st.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (st.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					unique case (st.op)
						CMD_ADD:   state_q <= st.key_zero ? S_DECIDE : S_HASH;
						CMD_READ:  state_q <= S_WAIT;
						CMD_CLEAR: state_q <= S_CLR;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_HASH: begin
					if (st.mix_done)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (st.op != CMD_ADD || stop)
						state_q <= S_DECIDE;
					else
						state_q <= S_WAIT;
				end
				S_CLR: begin
					if (st.clr_last)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/hash_accumulate_table.sv
// add: two 64-bit multiplies on a 32x32 unit hash the key, then slots are probed one after another
// read: one slot through the registered memory read; clear: key sweep over all SLOTS
// one word in flight; the next word is taken while a result waits in the output register
// zero key: straight to decide and commit without hashing; unused command: back to idle with no result word
// reset: asynchronous, then a sweep over all slots zeroes the key memory with input stalled
// the configuration register is written in any cycle
module hash_accumulate_table import hat_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int COUNT_LIMBS = COUNT_LIMBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [63:0] tag,
	input  logic [63:0] count_low,
	input  logic [63:0] count_high,
	input  logic [9:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        slot_used,
	output logic [63:0] slot_key,
	output logic [63:0] slot_tag,
	output logic [63:0] sum_low,
	output logic [63:0] sum_high,
	output logic [10:0] entry_total,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);

	hat_cmd_t  cmd;
	hat_stat_t st;

	hat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	hat_datapath #(
		.SLOTS       (SLOTS),
		.COUNT_LIMBS (COUNT_LIMBS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.command     (command),
		.key         (key),
		.tag         (tag),
		.count_low   (count_low),
		.count_high  (count_high),
		.slot_index  (slot_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_used   (slot_used),
		.slot_key    (slot_key),
		.slot_tag    (slot_tag),
		.sum_low     (sum_low),
		.sum_high    (sum_high),
		.entry_total (entry_total)
	);

endmodule

>>> rtl/hat_checker.sv
// port-level assertions for the hash accumulate table and their bind
module hat_port_checks import hat_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        slot_used,
	input logic [63:0] slot_key,
	input logic [63:0] sum_low,
	input logic [63:0] sum_high
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("output word dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_KEY || status == ST_TAG_MISS ||
		status == ST_OVERFLOW || status == ST_FULL || status == ST_CLEARED)
		|-> !slot_used && slot_key == 64'd0 && sum_low == 64'd0 && sum_high == 64'd0)
		else $error("error or clear word carries entry data");

	a_add_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INSERTED || status == ST_ACCUMULATED)
		|-> slot_used && slot_key != 64'd0)
		else $error("successful add without a stored key");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_READ && !slot_used |-> slot_key == 64'd0)
		else $error("empty slot read returns a key");

endmodule

bind hash_accumulate_table hat_port_checks u_hat_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.slot_used (slot_used),
	.slot_key  (slot_key),
	.sum_low   (sum_low),
	.sum_high  (sum_high)
);

>>> bench/hat_checker.sv
// checker for the hash accumulate table: predicts each result word and compares it
module hat_checker import hat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [63:0] tag,
	input  logic [63:0] count_low,
	input  logic [63:0] count_high,
	input  logic [9:0]  slot_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic        slot_used,
	input  logic [63:0] slot_key,
	input  logic [63:0] slot_tag,
	input  logic [63:0] sum_low,
	input  logic [63:0] sum_high,
	input  logic [10:0] entry_total,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0]  st;
		logic        used;
		logic [63:0] k;
		logic [63:0] t;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [10:0] total;
	} table_result_t;

	logic [63:0]  key_mem [SLOTS_DEF];
	logic [63:0]  tag_mem [SLOTS_DEF];
	logic [127:0] cnt_mem [SLOTS_DEF];
	logic [10:0]  held;
	logic [10:0]  limit;
	table_result_t results_due[$];

	assign pending = results_due.size();

	function automatic logic [63:0] home_hash(input logic [63:0] v);
		v = v ^ (v >> MIX_SH0);
		v = v * MIX_C1;
		v = v ^ (v >> MIX_SH1);
		v = v * MIX_C2;
		v = v ^ (v >> MIX_SH2);
		return v;
	endfunction

	task automatic apply_word(output table_result_t r, output bit has_result);
		int s;
		int n;
		bit found;
		bit empty;
		logic [128:0] total;
		r = '0;
		has_result = 1;
		found = 0;
		empty = 0;
		case (command)
			CMD_ADD: begin
				if (key == 0) begin
					r.st = ST_ZERO_KEY;
				end else begin
					s = int'(home_hash(key) & 64'(SLOTS_DEF - 1));
					for (n = 0; n < SLOTS_DEF; n++) begin
						if (key_mem[s] == 0) begin
							empty = 1;
							break;
						end
						if (key_mem[s] == key) begin
							found = 1;
							break;
						end
						s = (s + 1) % SLOTS_DEF;
					end
					if (found) begin
						total = {1'b0, cnt_mem[s]} + {1'b0, count_high, count_low};
						if (tag_mem[s] != tag) r.st = ST_TAG_MISS;
						else if (total[128]) r.st = ST_OVERFLOW;
						else begin
							cnt_mem[s] = total[127:0];
							r = '{ST_ACCUMULATED, 1'b1, key, tag, total[63:0], total[127:64], 11'd0};
						end
					end else if (!empty || 12'(held) + 12'd1 > 12'(limit)) begin
						r.st = ST_FULL;
					end else begin
						key_mem[s] = key;
						tag_mem[s] = tag;
						cnt_mem[s] = {count_high, count_low};
						held++;
						r = '{ST_INSERTED, 1'b1, key, tag, count_low, count_high, 11'd0};
					end
				end
			end
			CMD_READ: begin
				r.st = ST_READ;
				if (key_mem[slot_index] != 0) begin
					r.used = 1;
					r.k = key_mem[slot_index];
					r.t = tag_mem[slot_index];
					{r.hi, r.lo} = cnt_mem[slot_index];
				end
			end
			CMD_CLEAR: begin
				foreach (key_mem[i]) key_mem[i] = 0;
				held = 0;
				r.st = ST_CLEARED;
			end
			default: has_result = 0;
		endcase
		r.total = held;
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		table_result_t got;
		bit has;
		if (!arst_n) begin
			foreach (key_mem[i]) key_mem[i] = 0;
			held = 0;
			limit = LOAD_LIMIT_RST;
			results_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{status, slot_used, slot_key, slot_tag, sum_low, sum_high, entry_total};
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result word %p", got);
				end else begin
					e = results_due.pop_front();
					if (got !== e) begin
						fail_count++;
						if (fail_count <= 10) $display("expected %p actual %p", e, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_word(e, has);
				if (has) results_due.push_back(e);
			end
			if (cfg_we) limit = cfg_wdata;
		end
	end

endmodule

>>> bench/tb.sv
// top of the hash accumulate table testbench: stimulus, idle and stall phases and verdict
module tb;
	import hat_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = CMD_NONE;
	logic [63:0] key = 0;
	logic [63:0] tag = 0;
	logic [63:0] count_low = 0;
	logic [63:0] count_high = 0;
	logic [9:0]  slot_index = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic        slot_used;
	logic [63:0] slot_key, slot_tag, sum_low, sum_high;
	logic [10:0] entry_total;
	logic        cfg_we = 0;
	logic [10:0] cfg_wdata = 0;
	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_stall = 0;
	logic [63:0] key_pool [16];

	always #1 clk = ~clk;

	hash_accumulate_table uut (.*);

	hat_checker chk (.*);

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

	task automatic send_word(input logic [1:0] c, input logic [63:0] k, input logic [63:0] t,
		input logic [63:0] lo, input logic [63:0] hi, input logic [9:0] si);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		command <= c;
		key <= k;
		tag <= t;
		count_low <= lo;
		count_high <= hi;
		slot_index <= si;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (1100) @(negedge clk);
	endtask

	task automatic set_limit(input logic [10:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_word;
		logic [63:0] k;
		int p;
		p = $urandom_range(99);
		k = key_pool[$urandom_range(15)];
		if (p < 60)
			send_word(CMD_ADD, k, k ^ 64'h5a5a, {$urandom, $urandom},
				($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3)), 0);
		else if (p < 68)
			send_word(CMD_ADD, k, {$urandom, $urandom}, 0, 0, 0);
		else if (p < 73)
			send_word(CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, 0);
		else if (p < 76)
			send_word(CMD_ADD, 0, {$urandom, $urandom}, 0, 0, 0);
		else if (p < 94)
			send_word(CMD_READ, 0, 0, 0, 0, 10'($urandom));
		else if (p < 96)
			send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
		else
			send_word(CMD_NONE, {$urandom, $urandom}, 0, 0, 0, 10'($urandom));
	endtask

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int i;
		int ph;
		foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom} | 64'd1;
		key_pool[0] = 64'hffff_ffff_ffff_ffff;
		key_pool[1] = 64'd1;
		repeat (12) @(negedge clk);
		arst_n = 1;
		send_word(CMD_ADD, 0, 5, 5, 5, 0);
		send_word(CMD_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 0);
		send_word(CMD_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1, 0, 0);
		send_word(CMD_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0,
			64'h8000_0000_0000_0000, 0);
		send_word(CMD_ADD, 64'hffff_ffff_ffff_ffff, 0, 1, 0, 0);
		send_word(CMD_ADD, 1, 0, 64'hffff_ffff_ffff_ffff, 0, 0);
		send_word(CMD_ADD, 1, 0, 1, 0, 0);
		for (i = 0; i < 4; i++) send_word(CMD_ADD, 64'(i) * 1024 + 2, 1, 1, 1, 0);
		send_word(CMD_READ, 0, 0, 0, 0, 10'h3ff);
		send_word(CMD_READ, 0, 0, 0, 0, 0);
		send_word(CMD_NONE, 0, 0, 0, 0, 0);
		set_limit(11'd3);
		send_word(CMD_ADD, 64'h1234, 1, 1, 0, 0);
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
		set_limit(11'd0);
		send_word(CMD_ADD, 64'h1234, 1, 1, 0, 0);
		set_limit(11'd1024);
		for (ph = 0; ph < 5; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 83; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 83; end
				default: begin send_idle = 18; recv_stall = 18; end
			endcase
			for (i = 0; i < 110; i++) random_word();
			drain();
			set_limit(ph == 1 ? 11'd8 : ph == 2 ? 11'd714 : 11'($urandom_range(1024)));
		end
		set_limit(11'd20);
		send_idle = 0;
		recv_stall = 0;
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
		for (i = 0; i < 32; i++) send_word(CMD_ADD, {$urandom, $urandom} | 64'd1, 0, 1, 0, 0);
		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
